### hw/rtl/circ_pkg.sv
// Shared types and constants of the circle outline pixel generator.
package circ_pkg;

  localparam int unsigned CoordBits  = 16;
  localparam int unsigned RadiusBits = 15;
  // Walk point is two bits wider than the radius: y may reach r and x may pass zero.
  localparam int unsigned WalkBits   = RadiusBits + 2;
  localparam int unsigned ErrBits    = 20;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic [RadiusBits-1:0]       radius_t;
  typedef logic signed [WalkBits-1:0]  walk_t;
  typedef logic signed [ErrBits-1:0]   err_t;
  typedef logic [1:0]                  quad_t;

  typedef enum logic [0:0] {
    CmdStart = 1'b0,
    CmdStep  = 1'b1
  } cmd_e;

  // Next walk point of one quadrant, plus end-of-quadrant flag.
  typedef struct packed {
    walk_t x;
    walk_t y;
    err_t  err;
    logic  done;
  } walk_nxt_t;

endpackage

### hw/rtl/circ_if.sv
// Request and pixel channel interfaces of the circle outline pixel generator.
interface circ_req_if;
  import circ_pkg::*;

  logic    valid;
  logic    ready;
  logic    command;
  coord_t  center_x;
  coord_t  center_y;
  radius_t radius;
  logic    clockwise;

  modport source (output valid, command, center_x, center_y, radius, clockwise,
                  input ready);
  modport sink (input valid, command, center_x, center_y, radius, clockwise,
                output ready);
endinterface

interface circ_pix_if;
  import circ_pkg::*;

  logic   valid;
  logic   ready;
  coord_t pixel_x;
  coord_t pixel_y;
  logic   last;

  modport source (output valid, pixel_x, pixel_y, last, input ready);
  modport sink (input valid, pixel_x, pixel_y, last, output ready);
endinterface

### hw/rtl/circ_walk.sv
// One Bresenham step of the quadrant walk: next point, error and end flag.
module circ_walk (
  input  circ_pkg::walk_t     walk_x_i,
  input  circ_pkg::walk_t     walk_y_i,
  input  circ_pkg::err_t      err_i,
  output circ_pkg::walk_nxt_t nxt_o
);
  import circ_pkg::*;

  err_t  x_ext;
  err_t  y_ext;
  err_t  y1_ext;
  err_t  x1_ext;
  walk_t y1;
  walk_t x1;
  err_t  err1;
  err_t  err2;
  logic  step_y;
  logic  step_x;

  always_comb begin
    x_ext  = err_t'(walk_x_i);
    y_ext  = err_t'(walk_y_i);
    // Advance y while the old error is at most y
    step_y = (err_i <= y_ext);
    y1     = step_y ? walk_y_i + walk_t'(1) : walk_y_i;
    y1_ext = err_t'(y1);
    err1   = step_y ? err_i + (y1_ext <<< 1) + err_t'(1) : err_i;
    // Advance x on the old error against x or the new error against y
    step_x = (err_i > x_ext) || (err1 > y1_ext);
    x1     = step_x ? walk_x_i + walk_t'(1) : walk_x_i;
    x1_ext = err_t'(x1);
    err2   = step_x ? err1 + (x1_ext <<< 1) + err_t'(1) : err1;

    nxt_o.x    = x1;
    nxt_o.y    = y1;
    nxt_o.err  = err2;
    nxt_o.done = ~x1[WalkBits-1];
  end

endmodule

### hw/rtl/circ_map.sv
// Rotate or mirror the local walk point into the current quadrant about the centre.
module circ_map (
  input  circ_pkg::walk_t  walk_x_i,
  input  circ_pkg::walk_t  walk_y_i,
  input  circ_pkg::quad_t  quad_i,
  input  logic             clockwise_i,
  input  circ_pkg::coord_t center_x_i,
  input  circ_pkg::coord_t center_y_i,
  output circ_pkg::coord_t pixel_x_o,
  output circ_pkg::coord_t pixel_y_o
);
  import circ_pkg::*;

  walk_t  neg_x;
  coord_t a;
  coord_t b;
  coord_t dx;
  coord_t dy;
  quad_t  sel;

  always_comb begin
    neg_x = -walk_x_i;
    // Local point: clockwise walks (-x, y), counterclockwise (y, -x)
    if (clockwise_i) begin
      a = neg_x[CoordBits-1:0];
      b = walk_y_i[CoordBits-1:0];
    end else begin
      a = walk_y_i[CoordBits-1:0];
      b = neg_x[CoordBits-1:0];
    end
    // Counterclockwise runs the quadrants in reverse order
    sel = clockwise_i ? quad_i : ~quad_i;
    unique case (sel)
      2'd0: begin dx = a;  dy = b;  end
      2'd1: begin dx = -b; dy = a;  end
      2'd2: begin dx = -a; dy = -b; end
      default: begin dx = b;  dy = -a; end
    endcase
    pixel_x_o = center_x_i + dx;
    pixel_y_o = center_y_i + dy;
  end

endmodule

### hw/rtl/circle_outline_pixel_generator.sv
// Top level: takes start/step requests, keeps the walk state, registers one pixel per step.
// Latency: a step request's pixel is valid in the cycle after the request is taken.
// Throughput: one request per cycle; the request side stalls only while a pixel waits.
// Each step is a single pass through the walk and quadrant-mapping logic.
// Reset: asynchronous, active low; clears the drawing flag, quadrant and pixel valid.
module circle_outline_pixel_generator (
  input  logic       clk_i,
  input  logic       rst_ni,
  circ_req_if.sink   req_i,
  circ_pix_if.source rsp_o
);
  import circ_pkg::*;

  logic      drawing_q, drawing_d;
  quad_t     quad_q, quad_d;
  walk_t     walk_x_q, walk_x_d;
  walk_t     walk_y_q, walk_y_d;
  err_t      err_q, err_d;
  coord_t    center_x_q, center_x_d;
  coord_t    center_y_q, center_y_d;
  radius_t   radius_q, radius_d;
  logic      dir_q, dir_d;
  logic      out_valid_q, out_valid_d;
  coord_t    pix_x_q, pix_x_d;
  coord_t    pix_y_q, pix_y_d;
  logic      last_q, last_d;

  logic      accept;
  logic      do_step;
  walk_nxt_t nxt;
  coord_t    map_x;
  coord_t    map_y;
  walk_t     start_x;
  err_t      start_err;

  circ_walk u_walk (
    .walk_x_i (walk_x_q),
    .walk_y_i (walk_y_q),
    .err_i    (err_q),
    .nxt_o    (nxt)
  );

  circ_map u_map (
    .walk_x_i    (walk_x_q),
    .walk_y_i    (walk_y_q),
    .quad_i      (quad_q),
    .clockwise_i (dir_q),
    .center_x_i  (center_x_q),
    .center_y_i  (center_y_q),
    .pixel_x_o   (map_x),
    .pixel_y_o   (map_y)
  );

  // Take a request whenever the pixel register is free or being drained
  assign req_i.ready = ~out_valid_q | rsp_o.ready;
  assign accept      = req_i.valid & req_i.ready;
  assign do_step     = accept & (req_i.command == CmdStep) & drawing_q;

  // Quadrant start point (-r, 0) with error 2 - 2r
  always_comb begin
    if (req_i.command == CmdStart) begin
      start_x   = -walk_t'(req_i.radius);
      start_err = err_t'(2) - (err_t'(req_i.radius) <<< 1);
    end else begin
      start_x   = -walk_t'(radius_q);
      start_err = err_t'(2) - (err_t'(radius_q) <<< 1);
    end
  end

  // Walk state update
  always_comb begin
    drawing_d  = drawing_q;
    quad_d     = quad_q;
    walk_x_d   = walk_x_q;
    walk_y_d   = walk_y_q;
    err_d      = err_q;
    center_x_d = center_x_q;
    center_y_d = center_y_q;
    radius_d   = radius_q;
    dir_d      = dir_q;
    last_d     = last_q;
    pix_x_d    = pix_x_q;
    pix_y_d    = pix_y_q;
    if (accept && req_i.command == CmdStart) begin
      center_x_d = req_i.center_x;
      center_y_d = req_i.center_y;
      radius_d   = req_i.radius;
      dir_d      = req_i.clockwise;
      quad_d     = '0;
      drawing_d  = 1'b1;
      walk_x_d   = start_x;
      walk_y_d   = '0;
      err_d      = start_err;
    end else if (do_step) begin
      pix_x_d = map_x;
      pix_y_d = map_y;
      last_d  = 1'b0;
      if (nxt.done) begin
        if (quad_q == 2'd3) begin
          drawing_d = 1'b0;
          last_d    = 1'b1;
          walk_x_d  = nxt.x;
          walk_y_d  = nxt.y;
          err_d     = nxt.err;
        end else begin
          quad_d   = quad_q + 2'd1;
          walk_x_d = start_x;
          walk_y_d = '0;
          err_d    = start_err;
        end
      end else begin
        walk_x_d = nxt.x;
        walk_y_d = nxt.y;
        err_d    = nxt.err;
      end
    end
  end

  // Pixel register valid: set on a step, drop once taken
  always_comb begin
    if (do_step) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drawing_q   <= 1'b0;
      quad_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      drawing_q   <= drawing_d;
      quad_q      <= quad_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Walk and pixel payload
  always_ff @(posedge clk_i) begin
    walk_x_q   <= walk_x_d;
    walk_y_q   <= walk_y_d;
    err_q      <= err_d;
    center_x_q <= center_x_d;
    center_y_q <= center_y_d;
    radius_q   <= radius_d;
    dir_q      <= dir_d;
    pix_x_q    <= pix_x_d;
    pix_y_q    <= pix_y_d;
    last_q     <= last_d;
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.pixel_x = pix_x_q;
  assign rsp_o.pixel_y = pix_y_q;
  assign rsp_o.last    = last_q;

endmodule

### dv/circle_outline_pixel_checker.sv
// Checker: tracks the outline walk, predicts each pixel and compares it against the block.
module circle_outline_pixel_checker (
  input  logic clk_i,
  input  logic rst_ni,
  circ_req_if  req_i,
  circ_pix_if  rsp_i,
  output int   fail_count_o,
  output logic drawing_o,
  output logic busy_o
);
  import circ_pkg::*;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } outline_pixel_t;

  // Outline pixels predicted but not yet seen on the pixel channel
  outline_pixel_t outline_q[$];

  // Walk state of the circle in progress
  logic    drawing;
  quad_t   quad;
  int      walk_x;
  int      walk_y;
  int      walk_err;
  coord_t  held_x;
  coord_t  held_y;
  radius_t held_r;
  logic    held_cw;

  int mismatches = 0;
  int pending = 0;
  int retired = 0;

  assign fail_count_o = mismatches + pending;

  // Rewind the local point to the start of a quadrant
  function automatic void restart_walk();
    walk_x   = -int'(held_r);
    walk_y   = 0;
    walk_err = 2 - 2 * int'(held_r);
  endfunction

  // Emit the current point of the walk, mapped into its quadrant, then advance the walk
  function automatic void advance_outline();
    int a, b, dx, dy, e;
    quad_t slot;
    outline_pixel_t px;
    if (held_cw) begin
      a = -walk_x;
      b = walk_y;
    end else begin
      a = walk_y;
      b = -walk_x;
    end
    // counterclockwise quadrant k uses the clockwise mapping of quadrant 3 - k
    slot = held_cw ? quad : ~quad;
    case (slot)
      2'd0: begin
        dx = a;
        dy = b;
      end
      2'd1: begin
        dx = -b;
        dy = a;
      end
      2'd2: begin
        dx = -a;
        dy = -b;
      end
      default: begin
        dx = b;
        dy = -a;
      end
    endcase
    e = walk_err;
    if (e <= walk_y) begin
      walk_y   += 1;
      walk_err += 2 * walk_y + 1;
    end
    if (e > walk_x || walk_err > walk_y) begin
      walk_x   += 1;
      walk_err += 2 * walk_x + 1;
    end
    px.last = 1'b0;
    if (walk_x >= 0) begin
      if (quad == 2'd3) begin
        drawing = 1'b0;
        px.last = 1'b1;
      end else begin
        quad += 2'd1;
        restart_walk();
      end
    end
    // coordinates wrap to the coordinate width
    px.x = coord_t'(int'(held_x) + dx);
    px.y = coord_t'(int'(held_y) + dy);
    outline_q.push_back(px);
    pending++;
  endfunction

  // Retire pixels, then take requests; publish status for the stimulus side
  always @(posedge clk_i or negedge rst_ni) begin
    outline_pixel_t seen;
    outline_pixel_t want;
    if (!rst_ni) begin
      drawing  = 1'b0;
      quad     = '0;
      walk_x   = 0;
      walk_y   = 0;
      walk_err = 0;
      held_x   = '0;
      held_y   = '0;
      held_r   = '0;
      held_cw  = 1'b0;
      pending  = 0;
      outline_q.delete();
      drawing_o <= 1'b0;
      busy_o    <= 1'b0;
    end else begin
      if (rsp_i.valid && rsp_i.ready) begin
        seen.x    = rsp_i.pixel_x;
        seen.y    = rsp_i.pixel_y;
        seen.last = rsp_i.last;
        if (outline_q.size() == 0) begin
          if (mismatches < 10) begin
            $display("pixel %0d: none pending, got (%0d,%0d) last=%0b",
                     retired, seen.x, seen.y, seen.last);
          end
          mismatches++;
        end else begin
          want = outline_q.pop_front();
          pending--;
          if (seen.x !== want.x || seen.y !== want.y || seen.last !== want.last) begin
            if (mismatches < 10) begin
              $display("pixel %0d: expected (%0d,%0d) last=%0b, got (%0d,%0d) last=%0b",
                       retired, want.x, want.y, want.last, seen.x, seen.y, seen.last);
            end
            mismatches++;
          end
        end
        retired++;
      end
      if (req_i.valid && req_i.ready) begin
        if (req_i.command == CmdStart) begin
          held_x  = req_i.center_x;
          held_y  = req_i.center_y;
          held_r  = req_i.radius;
          held_cw = req_i.clockwise;
          quad    = '0;
          drawing = 1'b1;
          restart_walk();
        end else if (drawing) begin
          advance_outline();
        end
      end
      drawing_o <= drawing;
      busy_o    <= (pending != 0);
    end
  end

endmodule

### dv/tb_circle_outline_pixel_generator.sv
// Testbench top: drives start/step requests and pixel backpressure, reports the verdict.
module tb_circle_outline_pixel_generator;
  import circ_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  circ_req_if req_if ();
  circ_pix_if pix_if ();

  int   fail_count;
  logic drawing;
  logic busy;

  int   starts = 0;
  int   steps = 0;
  int   pixels = 0;
  int   outlines = 0;
  int   req_left = 0;
  logic req_quiet = 1'b0;
  logic req_idle = 1'b1;
  int   rsp_left = 0;
  logic rsp_quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  circle_outline_pixel_generator u_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (pix_if)
  );

  circle_outline_pixel_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .req_i        (req_if),
    .rsp_i        (pix_if),
    .fail_count_o (fail_count),
    .drawing_o    (drawing),
    .busy_o       (busy)
  );

  // Draw an idle gap; mix stretches without gaps and stretches with random gaps
  function automatic int draw_gap(inout int left, inout logic quiet);
    if (left == 0) begin
      quiet = ($urandom_range(0, 2) == 0);
      left  = $urandom_range(10, 60);
    end
    left--;
    return quiet ? 0 : $urandom_range(0, 15);
  endfunction

  // Present one request, hold it until taken, then idle for a drawn gap
  task automatic send_request(logic cmd, coord_t x, coord_t y, radius_t r, logic dir);
    int gap;
    req_if.valid     <= 1'b1;
    req_if.command   <= cmd;
    req_if.center_x  <= x;
    req_if.center_y  <= y;
    req_if.radius    <= r;
    req_if.clockwise <= dir;
    do @(posedge clk); while (!req_if.ready);
    if (cmd == CmdStart) starts++;
    else steps++;
    gap = draw_gap(req_left, req_quiet);
    req_idle = (gap > 0);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Step the outline until it ends or the step budget runs out; step payload is junk
  task automatic walk_outline(int max_steps, output int taken);
    taken = 0;
    do begin
      send_request(CmdStep, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom),
                   1'($urandom));
      taken++;
    end while (drawing && taken < max_steps);
  endtask

  // Hold off requests until every predicted pixel has come back
  task automatic settle();
    if (!req_idle) req_if.valid <= 1'b0;
    req_idle = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // Pixel side: random stalls between pixels
  initial begin
    int stall;
    pix_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap(rsp_left, rsp_quiet);
      if (stall > 0) begin
        pix_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pix_if.ready <= 1'b1;
      do @(posedge clk); while (!(pix_if.valid && pix_if.ready));
      pixels++;
      if (pix_if.last) outlines++;
    end
  end

  // Request side: directed circles, then random circles and noise
  initial begin
    int items;
    int taken;
    int pick;
    int r;
    int budget;
    coord_t x;
    coord_t y;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.command   <= CmdStep;
    req_if.center_x  <= '0;
    req_if.center_y  <= '0;
    req_if.radius    <= '0;
    req_if.clockwise <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // step before any circle: ignored
    send_request(CmdStep, 16'sd0, 16'sd0, '0, 1'b0);
    // radius zero: centre four times, then a step after the end
    send_request(CmdStart, 16'sd0, 16'sd0, 15'd0, 1'b1);
    walk_outline(4, taken);
    settle();
    send_request(CmdStep, -16'sd1, -16'sd1, 15'h7fff, 1'b1);
    // radius one counterclockwise on the wrap corner
    send_request(CmdStart, 16'sh7fff, 16'sh8000, 15'd1, 1'b0);
    walk_outline(4, taken);
    // largest radius, cut short by a restart
    send_request(CmdStart, 16'sh8000, 16'sh7fff, 15'h7fff, 1'b1);
    walk_outline(3, taken);
    send_request(CmdStart, 16'sh5555, 16'shaaaa, 15'd2, 1'b1);
    walk_outline(40, taken);
    // back-to-back starts
    send_request(CmdStart, 16'sd0, -16'sd1, 15'h7fff, 1'b0);
    send_request(CmdStart, 16'sd100, -16'sd100, 15'd3, 1'b1);
    settle();

    items = 0;
    while (items < 950) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        // noise: stray steps, mostly while idle
        repeat ($urandom_range(1, 3)) begin
          send_request(CmdStep, coord_t'($urandom), coord_t'($urandom), radius_t'($urandom),
                       1'($urandom));
        end
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) r = $urandom_range(0, 12);
        else if (pick < 9) r = $urandom_range(13, 40);
        else r = $urandom_range(41, 32767);
        if ($urandom_range(0, 3) == 0) begin
          // centre near the wrap point
          x = coord_t'(32'h8000 + $urandom_range(0, 80) - 40);
          y = coord_t'(32'h8000 + $urandom_range(0, 80) - 40);
        end else begin
          x = coord_t'($urandom);
          y = coord_t'($urandom);
        end
        if (r > 40) budget = $urandom_range(1, 80);
        else if ($urandom_range(0, 4) == 0) budget = $urandom_range(0, 4 * r + 3);
        else budget = 8 * r + 12;
        send_request(CmdStart, x, y, radius_t'(r), 1'($urandom));
        items++;
        if (budget > 0) begin
          walk_outline(budget, taken);
          items += taken;
        end
      end
      if ($urandom_range(0, 19) == 0) settle();
    end

    settle();
    repeat (8) @(posedge clk);
    $display("Covered %0d circle starts and %0d step requests; %0d outline pixels taken,",
             starts, steps, pixels);
    $display("%0d outlines finished, radii 0 to 32767, centers near and across the wrap point.",
             outlines);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Give up on a hung run
  initial begin
    #4800000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
